// File: hdl/ocpp_pkg.sv
`timescale 1ns / 1ps
package ocpp_pkg;

	localparam int FRAC_BITS_DEF  = 16;
	localparam int ANGLE_BITS_DEF = 16;
	localparam int QUEUE_DEPTH    = 4;
	localparam int ADDR_W         = 5;

	// register indexes
	localparam logic [2:0] REG_FOCAL     = 3'd0;
	localparam logic [2:0] REG_CENTER_X  = 3'd1;
	localparam logic [2:0] REG_CENTER_Y  = 3'd2;
	localparam logic [2:0] REG_AZIMUTH   = 3'd3;
	localparam logic [2:0] REG_ELEVATION = 3'd4;
	localparam logic [2:0] REG_RADIUS    = 3'd5;

	typedef struct packed {
		logic        [31:0] focal_pixels;
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic        [15:0] azimuth;
		logic        [15:0] elevation;
		logic        [31:0] orbit_radius;
	} cfg_t;

	// camera pose in Q30 plus camera position offsets
	typedef struct packed {
		logic signed [31:0] nsu;
		logic signed [31:0] cu;
		logic signed [31:0] ncc;
		logic signed [31:0] nsc;
		logic signed [31:0] sv;
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		logic signed [31:0] cv;
		logic signed [33:0] ox;
		logic signed [33:0] oy;
		logic signed [33:0] oz;
		logic               degen;
	} pose_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] pixel_u;
		logic signed [31:0] pixel_v;
		logic               invalid;
	} out_item_t;

	// camera-space point handed from front to back
	typedef struct packed {
		logic signed [37:0] cam_x;
		logic signed [37:0] cam_y;
		logic signed [37:0] cam_z;
		logic               zero_out;
	} mid_t;

endpackage

// File: hdl/ocpp_pose.sv
`timescale 1ns / 1ps
module ocpp_pose import ocpp_pkg::*; #(
	parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  restart,
	output pose_t pose,
	output logic  busy
);

	localparam int QS = ANGLE_BITS - 2;
	localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << QS;
	localparam logic signed [34:0] SIN_A = 35'sd1686629713;
	localparam logic signed [34:0] SIN_B = 35'sd688904866;
	localparam logic signed [32:0] SIN_C = 33'sd76016977;
	localparam logic [30:0] Q30_ONE = 31'd1 << 30;

	// sequencer steps: 16 polynomial steps, then pose products
	localparam logic [1:0] SUB_T2 = 2'd0;
	localparam logic [1:0] SUB_INNER = 2'd1;
	localparam logic [1:0] SUB_MID = 2'd2;
	localparam logic [1:0] SUB_SINE = 2'd3;
	localparam logic [4:0] ST_DX = 5'd16;
	localparam logic [4:0] ST_DY = 5'd17;
	localparam logic [4:0] ST_OX = 5'd18;
	localparam logic [4:0] ST_OY = 5'd19;
	localparam logic [4:0] ST_OZ = 5'd20;
	localparam logic [4:0] ST_NCC = 5'd21;
	localparam logic [4:0] ST_NSC = 5'd22;

	logic [4:0] step_q;
	logic busy_q;
	logic signed [32:0] t2_q, acc_q;
	logic signed [31:0] trig_q [4];
	logic signed [31:0] dx_q, dy_q, ncc_q, nsc_q;
	logic signed [33:0] ox_q, oy_q, oz_q;

	logic [ANGLE_BITS-1:0] ang;
	logic [1:0] quad;
	logic [30:0] t_raw, t_val;
	logic signed [32:0] op_a, op_b, rad;
	logic signed [34:0] prod;

	// (a*b)>>30, rounded on the magnitude
	function automatic logic signed [34:0] mq(input logic signed [32:0] a,
		input logic signed [32:0] b);
		logic [32:0] ua, ub;
		logic [65:0] p;
		logic [35:0] r;
		logic signed [34:0] rs;
		ua = a[32] ? 33'(-a) : 33'(a);
		ub = b[32] ? 33'(-b) : 33'(b);
		p = 66'(ua) * 66'(ub);
		r = 36'((p + (66'd1 << 29)) >> 30);
		rs = signed'(35'(r));
		return (a[32] ^ b[32]) ? -rs : rs;
	endfunction

	assign rad = signed'({1'b0, cfg.orbit_radius});

	// angle of the current polynomial pass
	always_comb begin
		unique case (step_q[3:2])
			2'd0: ang = ANGLE_BITS'(cfg.azimuth);
			2'd1: ang = ANGLE_BITS'(cfg.azimuth) + QUARTER;
			2'd2: ang = ANGLE_BITS'(cfg.elevation);
			default: ang = ANGLE_BITS'(cfg.elevation) + QUARTER;
		endcase
		quad = ang[ANGLE_BITS-1:ANGLE_BITS-2];
		t_raw = 31'(ang[QS-1:0]) << (30 - QS);
		t_val = quad[0] ? (Q30_ONE - t_raw) : t_raw;
	end

	// operand select for the shared multiplier
	always_comb begin
		op_a = '0;
		op_b = '0;
		if (step_q < ST_DX) begin
			unique case (step_q[1:0])
				SUB_T2: begin op_a = signed'({2'b0, t_val}); op_b = signed'({2'b0, t_val}); end
				SUB_INNER: begin op_a = t2_q; op_b = SIN_C; end
				SUB_MID: begin op_a = t2_q; op_b = acc_q; end
				SUB_SINE: begin op_a = signed'({2'b0, t_val}); op_b = acc_q; end
			endcase
		end else begin
			unique case (step_q)
				ST_DX: begin op_a = 33'(trig_q[1]); op_b = 33'(trig_q[2]); end
				ST_DY: begin op_a = 33'(trig_q[0]); op_b = 33'(trig_q[2]); end
				ST_OX: begin op_a = rad; op_b = 33'(dx_q); end
				ST_OY: begin op_a = rad; op_b = 33'(dy_q); end
				ST_OZ: begin op_a = rad; op_b = 33'(trig_q[3]); end
				ST_NCC: begin op_a = 33'(trig_q[1]); op_b = 33'(trig_q[3]); end
				ST_NSC: begin op_a = 33'(trig_q[0]); op_b = 33'(trig_q[3]); end
				default: begin op_a = '0; op_b = '0; end
			endcase
		end
	end

	assign prod = mq(op_a, op_b);

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			busy_q <= 1'b1;
		end else if (restart) begin
			step_q <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (step_q == ST_NSC) begin
				busy_q <= 1'b0;
			end
			step_q <= step_q + 5'd1;
		end
	end

	// result write-back
	always_ff @(posedge clk) begin
		if (busy_q && !restart) begin
			if (step_q < ST_DX) begin
				unique case (step_q[1:0])
					SUB_T2: t2_q <= 33'(prod);
					SUB_INNER: acc_q <= 33'(SIN_B - prod);
					SUB_MID: acc_q <= 33'(SIN_A - prod);
					SUB_SINE: trig_q[step_q[3:2]] <= 32'(quad[1] ? -prod : prod);
				endcase
			end else begin
				unique case (step_q)
					ST_DX: dx_q <= 32'(prod);
					ST_DY: dy_q <= 32'(prod);
					ST_OX: ox_q <= 34'(prod);
					ST_OY: oy_q <= 34'(prod);
					ST_OZ: oz_q <= 34'(prod);
					ST_NCC: ncc_q <= 32'(-prod);
					ST_NSC: nsc_q <= 32'(-prod);
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		pose.nsu = -trig_q[0];
		pose.cu = trig_q[1];
		pose.ncc = ncc_q;
		pose.nsc = nsc_q;
		pose.sv = trig_q[2];
		pose.dx = dx_q;
		pose.dy = dy_q;
		pose.cv = trig_q[3];
		pose.ox = ox_q;
		pose.oy = oy_q;
		pose.oz = oz_q;
		// sine of elevation is zero on a multiple of a half turn
		pose.degen = (ANGLE_BITS'(cfg.elevation) & ((ANGLE_BITS'(1) << (ANGLE_BITS - 1))
			- ANGLE_BITS'(1))) == '0;
	end

	assign busy = busy_q;

endmodule

// File: hdl/ocpp_front.sv
`timescale 1ns / 1ps
module ocpp_front import ocpp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  pose_t    pose,
	input  logic     take,
	input  in_item_t item,
	output logic     advance,
	output logic     mid_valid,
	output mid_t     mid,
	input  logic     mid_ready
);

	logic v_s1, v_s2, v_s3;
	logic signed [34:0] qx_s1, qy_s1, qz_s1;
	logic dg_s1, dg_s2;
	logic signed [35:0] tx0_s2, tx1_s2, ty0_s2, ty1_s2, ty2_s2, tz0_s2, tz1_s2, tz2_s2;
	mid_t mid_s3;
	logic signed [37:0] zsum;

	function automatic logic signed [35:0] mulq(input logic signed [31:0] a,
		input logic signed [34:0] b);
		logic [31:0] ua;
		logic [34:0] ub;
		logic [66:0] p;
		logic [36:0] r;
		logic signed [35:0] rs;
		ua = a[31] ? 32'(-a) : 32'(a);
		ub = b[34] ? 35'(-b) : 35'(b);
		p = 67'(ua) * 67'(ub);
		r = 37'((p + (67'd1 << 29)) >> 30);
		rs = signed'(36'(r));
		return (a[31] ^ b[34]) ? -rs : rs;
	endfunction

	assign advance = !(v_s3 && !mid_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (advance) begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign zsum = 38'(tz0_s2) + 38'(tz1_s2) + 38'(tz2_s2);

	always_ff @(posedge clk) begin
		if (advance) begin
			// offset from camera position
			qx_s1 <= 35'(item.point_x) - 35'(pose.ox);
			qy_s1 <= 35'(item.point_y) - 35'(pose.oy);
			qz_s1 <= 35'(item.point_z) - 35'(pose.oz);
			dg_s1 <= pose.degen;
			// rotation terms
			tx0_s2 <= mulq(pose.nsu, qx_s1);
			tx1_s2 <= mulq(pose.cu, qy_s1);
			ty0_s2 <= mulq(pose.ncc, qx_s1);
			ty1_s2 <= mulq(pose.nsc, qy_s1);
			ty2_s2 <= mulq(pose.sv, qz_s1);
			tz0_s2 <= mulq(pose.dx, qx_s1);
			tz1_s2 <= mulq(pose.dy, qy_s1);
			tz2_s2 <= mulq(pose.cv, qz_s1);
			dg_s2 <= dg_s1;
			// sums and classification
			mid_s3.cam_x <= 38'(tx0_s2) + 38'(tx1_s2);
			mid_s3.cam_y <= 38'(ty0_s2) + 38'(ty1_s2) + 38'(ty2_s2);
			mid_s3.cam_z <= -zsum;
			mid_s3.zero_out <= dg_s2 || (zsum == '0);
		end
	end

	assign mid_valid = v_s3;
	assign mid = mid_s3;

endmodule

// File: hdl/ocpp_queue.sv
`timescale 1ns / 1ps
module ocpp_queue import ocpp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	input  mid_t push_data,
	output logic push_ready,
	output logic pop_valid,
	output mid_t pop_data,
	input  logic pop_ready
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	mid_t mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0] count_q;
	logic do_push, do_pop;

	assign push_ready = count_q < (PW+1)'(QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + PW'(1);
			end
			count_q <= count_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

// File: hdl/ocpp_back.sv
`timescale 1ns / 1ps
module ocpp_back import ocpp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      mid_valid,
	input  mid_t      mid,
	output logic      mid_ready,
	output logic      out_valid,
	output out_item_t out_item,
	input  logic      out_ready
);

	localparam int QBITS = 40;

	typedef struct packed {
		logic [37:0] rem;
		logic [39:0] low;
	} lane_t;

	typedef struct packed {
		logic [37:0] den;
		logic        neg_u;
		logic        neg_v;
		logic        big_u;
		logic        big_v;
		logic        zero_out;
	} carry_t;

	typedef struct packed {
		logic signed [31:0] val;
		logic               sat;
	} axis_t;

	logic en;
	logic v_b1, v_b2;
	logic [37:0] ax_b1, ay_b1, den_b1;
	logic nu_b1, nv_b1, zo_b1;
	logic [50:0] xlo_b2, xhi_b2, ylo_b2, yhi_b2;
	logic [37:0] den_b2;
	logic nu_b2, nv_b2, zo_b2;
	logic [69:0] nx, ny;
	logic dv [QBITS+1];
	lane_t lx [QBITS+1];
	lane_t ly [QBITS+1];
	carry_t cr [QBITS+1];
	logic v_out_q;
	out_item_t out_q;
	axis_t au, av;

	function automatic lane_t div_step(input lane_t l, input logic [37:0] den);
		logic [38:0] t;
		lane_t r;
		t = {l.rem, l.low[39]};
		if (t >= {1'b0, den}) begin
			r.rem = 38'(t - {1'b0, den});
			r.low = {l.low[38:0], 1'b1};
		end else begin
			r.rem = t[37:0];
			r.low = {l.low[38:0], 1'b0};
		end
		return r;
	endfunction

	// rounding, saturation and principal point offset
	function automatic axis_t finish(input lane_t l, input logic [37:0] den,
		input logic neg, input logic big, input logic signed [31:0] c);
		logic [40:0] qr;
		logic signed [41:0] s;
		logic signed [42:0] total;
		axis_t r;
		qr = 41'(l.low) + 41'({l.rem, 1'b0} >= {1'b0, den});
		s = neg ? -signed'(42'(qr)) : signed'(42'(qr));
		total = 43'(c) + 43'(s);
		if (big || qr > (41'd1 << 40)) begin
			r.sat = 1'b1;
			r.val = neg ? 32'sh80000000 : 32'sh7FFFFFFF;
		end else if (total > 43'sd2147483647) begin
			r.sat = 1'b1;
			r.val = 32'sh7FFFFFFF;
		end else if (total < -43'sd2147483648) begin
			r.sat = 1'b1;
			r.val = 32'sh80000000;
		end else begin
			r.sat = 1'b0;
			r.val = 32'(total);
		end
		return r;
	endfunction

	assign en = !v_out_q || out_ready;
	assign mid_ready = en;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
			v_b2 <= 1'b0;
			v_out_q <= 1'b0;
			for (int k = 0; k <= QBITS; k++) begin
				dv[k] <= 1'b0;
			end
		end else if (en) begin
			v_b1 <= mid_valid;
			v_b2 <= v_b1;
			dv[0] <= v_b2;
			for (int k = 0; k < QBITS; k++) begin
				dv[k+1] <= dv[k];
			end
			v_out_q <= dv[QBITS];
		end
	end

	assign nx = 70'(xlo_b2) + (70'(xhi_b2) << 19);
	assign ny = 70'(ylo_b2) + (70'(yhi_b2) << 19);

	// magnitudes, numerator products, division setup
	always_ff @(posedge clk) begin
		if (en) begin
			ax_b1 <= mid.cam_x[37] ? 38'(-mid.cam_x) : 38'(mid.cam_x);
			ay_b1 <= mid.cam_y[37] ? 38'(-mid.cam_y) : 38'(mid.cam_y);
			den_b1 <= mid.cam_z[37] ? 38'(-mid.cam_z) : 38'(mid.cam_z);
			nu_b1 <= mid.cam_x[37] ^ mid.cam_z[37];
			nv_b1 <= mid.cam_y[37] ^ mid.cam_z[37];
			zo_b1 <= mid.zero_out;

			xlo_b2 <= 51'(cfg.focal_pixels) * 51'(ax_b1[18:0]);
			xhi_b2 <= 51'(cfg.focal_pixels) * 51'(ax_b1[37:19]);
			ylo_b2 <= 51'(cfg.focal_pixels) * 51'(ay_b1[18:0]);
			yhi_b2 <= 51'(cfg.focal_pixels) * 51'(ay_b1[37:19]);
			den_b2 <= den_b1;
			nu_b2 <= nu_b1;
			nv_b2 <= nv_b1;
			zo_b2 <= zo_b1;

			// quotient of 2^40 or more saturates
			lx[0].rem <= 38'(nx[69:40]);
			lx[0].low <= nx[39:0];
			ly[0].rem <= 38'(ny[69:40]);
			ly[0].low <= ny[39:0];
			cr[0].den <= den_b2;
			cr[0].neg_u <= nu_b2;
			cr[0].neg_v <= nv_b2;
			cr[0].big_u <= 38'(nx[69:40]) >= den_b2;
			cr[0].big_v <= 38'(ny[69:40]) >= den_b2;
			cr[0].zero_out <= zo_b2;
		end
	end

	// one quotient bit per stage
	for (genvar k = 0; k < QBITS; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (en) begin
				lx[k+1] <= div_step(lx[k], cr[k].den);
				ly[k+1] <= div_step(ly[k], cr[k].den);
				cr[k+1] <= cr[k];
			end
		end
	end

	assign au = finish(lx[QBITS], cr[QBITS].den, cr[QBITS].neg_u, cr[QBITS].big_u,
		cfg.center_x);
	assign av = finish(ly[QBITS], cr[QBITS].den, cr[QBITS].neg_v, cr[QBITS].big_v,
		cfg.center_y);

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			if (cr[QBITS].zero_out) begin
				out_q.pixel_u <= '0;
				out_q.pixel_v <= '0;
				out_q.invalid <= 1'b1;
			end else begin
				out_q.pixel_u <= au.val;
				out_q.pixel_v <= av.val;
				out_q.invalid <= au.sat || av.sat;
			end
		end
	end

	assign out_valid = v_out_q;
	assign out_item = out_q;

endmodule

// File: hdl/orbit_camera_point_projection_top.sv
`timescale 1ns / 1ps
// channel   signals                           payload
// in        in_valid / in_ready               in_item  (point_x, point_y, point_z)
// out       out_valid / out_ready             out_item (pixel_u, pixel_v, invalid)
// config    psel penable pwrite paddr pwdata  prdata, pready tied high
//
// One item per cycle sustained unless an output stall or pose update holds it.
// Acceptance to out_valid: 3 transform stages, queue, 3 setup stages, 40 divider
// stages, output register. The pose sequencer shares one multiplier after reset and
// on any write to azimuth, elevation or orbit_radius; in_ready is low while it runs.
// Output stalls hold the back pipeline; the 4-entry queue lets the front keep going.
module orbit_camera_point_projection_top import ocpp_pkg::*; #(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_item,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t cfg_q;
	pose_t pose;
	logic busy, restart, wr, take, advance;
	logic [2:0] idx;
	logic mid_valid, mid_ready, pop_valid, pop_ready;
	mid_t mid, pop_data;

	assign pready = 1'b1;
	assign idx = paddr[4:2];
	assign wr = psel && penable && pwrite;
	assign restart = wr && (idx == REG_AZIMUTH || idx == REG_ELEVATION || idx == REG_RADIUS);

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.focal_pixels <= 32'(64'd1 << FRAC_BITS);
			cfg_q.center_x <= '0;
			cfg_q.center_y <= '0;
			cfg_q.azimuth <= '0;
			cfg_q.elevation <= 16'((64'd1 << ANGLE_BITS) >> 2);
			cfg_q.orbit_radius <= 32'(64'd1 << FRAC_BITS);
		end else if (wr) begin
			unique case (idx)
				REG_FOCAL: cfg_q.focal_pixels <= pwdata;
				REG_CENTER_X: cfg_q.center_x <= signed'(pwdata);
				REG_CENTER_Y: cfg_q.center_y <= signed'(pwdata);
				REG_AZIMUTH: cfg_q.azimuth <= pwdata[15:0];
				REG_ELEVATION: cfg_q.elevation <= pwdata[15:0];
				REG_RADIUS: cfg_q.orbit_radius <= pwdata;
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (idx)
			REG_FOCAL: prdata = cfg_q.focal_pixels;
			REG_CENTER_X: prdata = cfg_q.center_x;
			REG_CENTER_Y: prdata = cfg_q.center_y;
			REG_AZIMUTH: prdata = 32'(cfg_q.azimuth);
			REG_ELEVATION: prdata = 32'(cfg_q.elevation);
			REG_RADIUS: prdata = cfg_q.orbit_radius;
			default: prdata = '0;
		endcase
	end

	assign in_ready = advance && !busy;
	assign take = in_valid && in_ready;

	ocpp_pose #(.ANGLE_BITS(ANGLE_BITS)) u_pose (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .restart(restart),
		.pose(pose), .busy(busy)
	);

	ocpp_front u_front (
		.clk(clk), .arst_n(arst_n), .pose(pose), .take(take), .item(in_item),
		.advance(advance), .mid_valid(mid_valid), .mid(mid), .mid_ready(mid_ready)
	);

	ocpp_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push_valid(mid_valid), .push_data(mid), .push_ready(mid_ready),
		.pop_valid(pop_valid), .pop_data(pop_data), .pop_ready(pop_ready)
	);

	ocpp_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.mid_valid(pop_valid), .mid(pop_data), .mid_ready(pop_ready),
		.out_valid(out_valid), .out_item(out_item), .out_ready(out_ready)
	);

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
	import ocpp_pkg::*;

	// sine polynomial coefficients, Q30
	localparam longint SIN_A   = 64'sd1686629713;
	localparam longint SIN_B   = 2 * SIN_A - (64'sd5 <<< 29);
	localparam longint SIN_C   = SIN_A - (64'sd3 <<< 29);
	localparam longint Q30_ONE = 64'sd1 <<< 30;
	localparam longint ONE_Q16 = 64'sd65536;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	in_item_t          in_item = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	out_item_t         out_item;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	cfg_t      cam_cfg;
	out_item_t pending_pixels[$];
	int        mismatch_cnt = 0;
	int        long_hold = 0;
	bit        calm = 1'b0;

	orbit_camera_point_projection_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Q30 product, round to nearest, ties away from zero
	function automatic longint q30_mul(longint a, longint b);
		bit        neg;
		bit [63:0] ua, ub, r;
		neg = (a < 0) != (b < 0);
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		r = (ua * ub + (64'd1 << 29)) >> 30;
		return neg ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint quarter_wave(longint t);
		longint t2, inner, mid;
		t2 = q30_mul(t, t);
		inner = SIN_B - q30_mul(t2, SIN_C);
		mid = SIN_A - q30_mul(t2, inner);
		return q30_mul(t, mid);
	endfunction

	function automatic longint turn_sine(logic [15:0] a);
		longint t, s;
		t = longint'(a[13:0]) <<< 16;
		if (a[14])
			t = Q30_ONE - t;
		s = quarter_wave(t);
		return a[15] ? -s : s;
	endfunction

	function automatic longint turn_cosine(logic [15:0] a);
		logic [15:0] b;
		b = a + 16'd16384;
		return turn_sine(b);
	endfunction

	// c + f*x/z; returns {saturated, coordinate}
	function automatic logic [32:0] axis_to_pixel(logic [31:0] f, longint x, longint z,
			longint c);
		bit         neg;
		bit [127:0] num, den, quo, rem;
		bit         sat;
		longint     s, total;
		neg = (x < 0) != (z < 0);
		num = {96'd0, f} * {64'd0, 64'((x < 0) ? -x : x)};
		den = {64'd0, 64'((z < 0) ? -z : z)};
		quo = num / den;
		rem = num % den;
		sat = quo >= (128'd1 << 40);
		if (2 * rem >= den)
			quo = quo + 1;
		if (sat || quo > (128'd1 << 40))
			return {1'b1, neg ? 32'h8000_0000 : 32'h7FFF_FFFF};
		s = neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
		total = c + s;
		if (total > 64'sd2147483647)
			return {1'b1, 32'h7FFF_FFFF};
		if (total < -64'sd2147483648)
			return {1'b1, 32'h8000_0000};
		return {1'b0, total[31:0]};
	endfunction

	function automatic out_item_t project_point(in_item_t p);
		out_item_t   o;
		longint      su, cu, sv, cv, dx, dy, rad, qx, qy, qz, cx, cy, cz;
		logic [32:0] r;
		o = '0;
		su = turn_sine(cam_cfg.azimuth);
		cu = turn_cosine(cam_cfg.azimuth);
		sv = turn_sine(cam_cfg.elevation);
		cv = turn_cosine(cam_cfg.elevation);
		rad = longint'(cam_cfg.orbit_radius);
		if (cam_cfg.elevation[14:0] == 15'd0) begin
			o.invalid = 1'b1;
			return o;
		end
		dx = q30_mul(cu, sv);
		dy = q30_mul(su, sv);
		qx = longint'(p.point_x) - q30_mul(rad, dx);
		qy = longint'(p.point_y) - q30_mul(rad, dy);
		qz = longint'(p.point_z) - q30_mul(rad, cv);
		cx = q30_mul(-su, qx) + q30_mul(cu, qy);
		cy = q30_mul(-q30_mul(cu, cv), qx) + q30_mul(-q30_mul(su, cv), qy) + q30_mul(sv, qz);
		cz = -(q30_mul(dx, qx) + q30_mul(dy, qy) + q30_mul(cv, qz));
		if (cz == 0) begin
			o.invalid = 1'b1;
			return o;
		end
		r = axis_to_pixel(cam_cfg.focal_pixels, cx, cz, longint'(cam_cfg.center_x));
		o.pixel_u = r[31:0];
		o.invalid = r[32];
		r = axis_to_pixel(cam_cfg.focal_pixels, cy, cz, longint'(cam_cfg.center_y));
		o.pixel_v = r[31:0];
		o.invalid = o.invalid | r[32];
		return o;
	endfunction

	// register write: setup phase, access phase, then an idle phase
	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_FOCAL:     cam_cfg.focal_pixels = val;
			REG_CENTER_X:  cam_cfg.center_x = val;
			REG_CENTER_Y:  cam_cfg.center_y = val;
			REG_AZIMUTH:   cam_cfg.azimuth = val[15:0];
			REG_ELEVATION: cam_cfg.elevation = val[15:0];
			REG_RADIUS:    cam_cfg.orbit_radius = val;
			default: ;
		endcase
	endtask

	task automatic set_camera(logic [31:0] f, logic [31:0] cx, logic [31:0] cy,
			logic [15:0] az, logic [15:0] el, logic [31:0] rad);
		write_reg(REG_FOCAL, f);
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_AZIMUTH, {16'd0, az});
		write_reg(REG_ELEVATION, {16'd0, el});
		write_reg(REG_RADIUS, rad);
	endtask

	// offer one point, return at the edge that accepts it
	task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		in_item_t p;
		p.point_x = x;
		p.point_y = y;
		p.point_z = z;
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= p;
		pending_pixels = {pending_pixels, project_point(p)};
		@(negedge clk);
		while (!in_ready)
			@(negedge clk);
		@(posedge clk);
	endtask

	// stop offering and wait for every pending result
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
	endfunction

	task automatic send_random(int n);
		repeat (n) send_point(rand_coord(), rand_coord(), rand_coord());
	endtask

	// reset pose: camera at (1,0,0) looking down -x
	task automatic test_reset_pose();
		send_point(32'h0, 32'h0, 32'h0);
		send_point(32'h0001_0000, 32'h0, 32'h0);        // zero depth
		send_point(32'h0002_0000, 32'h0003_0000, 32'h0); // behind the camera
		send_point(32'h0, 32'h0001_0000, 32'hFFFF_0000);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_point(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
		send_point(32'h0000_FFFF, 32'h8000_0000, 32'h0000_0001);
		drain();
	endtask

	// elevation at a multiple of a half turn
	task automatic test_degenerate_pose();
		write_reg(REG_ELEVATION, 32'd0);
		send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
		send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
		drain();
		write_reg(REG_ELEVATION, 32'd32768);
		send_point(32'h0, 32'h0, 32'h0);
		send_point(32'h0001_0000, 32'h0, 32'h0);
		drain();
	endtask

	task automatic test_register_extremes();
		set_camera(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		send_random(4);
		drain();
		set_camera(32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0, 16'h0001, 32'h0);
		send_random(4);
		drain();
		set_camera(32'h0200_0000, 32'h0, 32'h0, 16'h4000, 16'h7FFF, 32'h0004_0000);
		send_point(32'h0, 32'h0, 32'h0);
		send_point(32'h0000_8000, 32'hFFFF_8000, 32'h0001_0000);
		drain();
	endtask

	task automatic random_camera();
		logic [15:0] el;
		el = $urandom;
		if ($urandom_range(0, 9) == 0)
			el = $urandom_range(0, 1) ? 16'd0 : 16'd32768;
		set_camera($urandom_range(ONE_Q16, 32'h0400_0000),
			$urandom_range(0, 32'h0400_0000) - 32'h0200_0000,
			$urandom_range(0, 32'h0400_0000) - 32'h0200_0000,
			$urandom, el, $urandom_range(ONE_Q16, 32'h0010_0000));
	endtask

	task automatic test_random_poses();
		repeat (8) begin
			random_camera();
			send_random(50);
			drain();
		end
	endtask

	// receiver holds off long enough to fill the block, sender keeps offering
	task automatic test_backpressure();
		random_camera();
		long_hold = 300;
		send_random(60);
		drain();
	endtask

	task automatic test_streaming();
		calm = 1'b1;
		random_camera();
		send_random(80);
		drain();
	endtask

	// receiver: random short stalls, or a long hold on request
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (long_hold > 0) begin
				out_ready <= 1'b0;
				long_hold--;
			end else begin
				if (!calm && stall_left == 0 && $urandom_range(0, 7) == 0)
					stall_left = $urandom_range(1, 3);
				if (stall_left > 0) begin
					out_ready <= 1'b0;
					stall_left--;
				end else begin
					out_ready <= 1'b1;
				end
			end
		end
	end

	// compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		out_item_t want;
		if (out_valid && out_ready) begin
			if (pending_pixels.size() == 0) begin
				$error("unexpected result u=%h v=%h", out_item.pixel_u, out_item.pixel_v);
				mismatch_cnt++;
			end else begin
				want = pending_pixels.pop_front();
				if (out_item.pixel_u !== want.pixel_u) begin
					$error("pixel_u: expected %h, got %h", want.pixel_u, out_item.pixel_u);
					mismatch_cnt++;
				end
				if (out_item.pixel_v !== want.pixel_v) begin
					$error("pixel_v: expected %h, got %h", want.pixel_v, out_item.pixel_v);
					mismatch_cnt++;
				end
				if (out_item.invalid !== want.invalid) begin
					$error("invalid: expected %b, got %b", want.invalid, out_item.invalid);
					mismatch_cnt++;
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("tb: FAIL");
		$finish;
	end

	initial begin
		cam_cfg.focal_pixels = 32'h0001_0000;
		cam_cfg.center_x = '0;
		cam_cfg.center_y = '0;
		cam_cfg.azimuth = 16'd0;
		cam_cfg.elevation = 16'd16384;
		cam_cfg.orbit_radius = 32'h0001_0000;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_pose();
		test_degenerate_pose();
		test_register_extremes();
		test_random_poses();
		test_backpressure();
		test_streaming();
		repeat (60) @(posedge clk);
		if (mismatch_cnt == 0 && pending_pixels.size() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

// File: orbit_camera_point_projection_top.f
hdl/ocpp_pkg.sv
hdl/ocpp_pose.sv
hdl/ocpp_front.sv
hdl/ocpp_queue.sv
hdl/ocpp_back.sv
hdl/orbit_camera_point_projection_top.sv
tb/sv/tb.sv
